// File: rtl/mbe_pkg.sv
package mbe_pkg;

  // fixed point format of the core
  localparam int FracBits   = 44;
  localparam int ImageSize  = 512;

  localparam int CfgWidth   = 48;
  localparam int ZoomWidth  = 6;
  localparam int IndexWidth = 9;
  localparam int StepsWidth = 9;

  // pixel offset: (2*index - ImageSize + 1) << (FracBits - 1), then >>> zoom
  localparam int OffWidth   = IndexWidth + FracBits + 1;
  localparam int SumWidth   = OffWidth + 1;
  // point c, saturated to [-8, 8)
  localparam int CoordWidth = FracBits + 4;
  // iterate z stays within (-12, 12)
  localparam int ZWidth     = FracBits + 5;
  localparam int MagWidth   = FracBits + 4;
  localparam int LoWidth    = MagWidth / 2;
  localparam int HiWidth    = MagWidth - LoWidth;
  localparam int ProdWidth  = 2 * MagWidth;
  // |z|^2 >= 4 in product scale
  localparam int EscBit     = 2 * FracBits + 2;

  typedef enum logic [1:0] {
    REG_CENTRE_X = 2'd0,
    REG_CENTRE_Y = 2'd1,
    REG_ZOOM     = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic pix_load;
    logic offset_calc;
    logic point_load;
    logic mul_en;
    logic sum_en;
    logic z_step;
  } mbe_cmd_t;

  typedef struct packed {
    logic finished;
  } mbe_sts_t;

endpackage

// File: rtl/mbe_ctrl.sv
module mbe_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             out_free,
  output logic             out_load,
  output mbe_pkg::mbe_cmd_t cmd,
  input  mbe_pkg::mbe_sts_t sts
);
  import mbe_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_OFFSET = 7'b0000010,
    ST_POINT  = 7'b0000100,
    ST_MUL    = 7'b0001000,
    ST_SUM    = 7'b0010000,
    ST_TEST   = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.pix_load = 1'b1;
          state_nxt    = ST_OFFSET;
        end
      end
      ST_OFFSET: begin
        cmd.offset_calc = 1'b1;
        state_nxt       = ST_POINT;
      end
      ST_POINT: begin
        cmd.point_load = 1'b1;
        state_nxt      = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_en = 1'b1;
        state_nxt  = ST_TEST;
      end
      ST_TEST: begin
        if (sts.finished) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd.z_step = 1'b1;
          state_nxt  = ST_MUL;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_no_step_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.z_step |-> !sts.finished)
    else $error("iterate advanced past escape or step limit");

endmodule

// File: rtl/mbe_datapath.sv
module mbe_datapath #(
  parameter int MAX_STEPS = 256
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  mbe_pkg::mbe_cmd_t                      cmd,
  output mbe_pkg::mbe_sts_t                      sts,
  input  logic        [mbe_pkg::IndexWidth-1:0]  pixel_column,
  input  logic        [mbe_pkg::IndexWidth-1:0]  pixel_row,
  input  logic signed [mbe_pkg::CfgWidth-1:0]    centre_x,
  input  logic signed [mbe_pkg::CfgWidth-1:0]    centre_y,
  input  logic        [mbe_pkg::ZoomWidth-1:0]   zoom_level,
  output logic        [mbe_pkg::StepsWidth-1:0]  escape_steps
);
  import mbe_pkg::*;

  localparam int CntWidth = $clog2(MAX_STEPS + 1);

  function automatic logic signed [CoordWidth-1:0] sat_coord(
    input logic signed [SumWidth-1:0] v
  );
    logic [SumWidth-CoordWidth:0] top;
    top = v[SumWidth-1:CoordWidth-1];
    if (top == '0 || top == '1) begin
      return $signed(v[CoordWidth-1:0]);
    end else if (v[SumWidth-1]) begin
      return $signed({1'b1, {(CoordWidth-1){1'b0}}});
    end else begin
      return $signed({1'b0, {(CoordWidth-1){1'b1}}});
    end
  endfunction

  logic        [IndexWidth-1:0] col_r, row_r;
  logic signed [OffWidth-1:0]   off_x_r, off_y_r;
  logic signed [CoordWidth-1:0] c_x_r, c_y_r;
  logic signed [ZWidth-1:0]     z_x_r, z_y_r;
  logic        [CntWidth-1:0]   steps_r;

  // partial products of the 48-bit magnitudes, split into halves
  logic [2*HiWidth-1:0]         xhh_r, yhh_r, xyhh_r;
  logic [HiWidth+LoWidth-1:0]   xhl_r, yhl_r, xyhl_r, xylh_r;
  logic [2*LoWidth-1:0]         xll_r, yll_r, xyll_r;
  logic                         xy_neg_r, xy_neg_mul_r;
  logic [ProdWidth-1:0]         xx_r, yy_r, xy_r;

  // offsets: 2*index + 1 - ImageSize
  logic signed [OffWidth-1:0]   m_x, m_y;
  logic signed [SumWidth-1:0]   sum_x, sum_y;
  logic signed [ZWidth-1:0]     abs_x, abs_y;
  logic        [MagWidth-1:0]   mag_x, mag_y;
  logic        [HiWidth-1:0]    xh, yh;
  logic        [LoWidth-1:0]    xl, yl;
  logic        [ProdWidth-1:0]  xx_nxt, yy_nxt, xy_nxt;
  logic        [ProdWidth:0]    r2;
  logic                         escape;
  logic signed [ProdWidth:0]    diff, diff_sh;
  logic signed [ProdWidth+1:0]  p2, p2_sgn, p2_sh;
  logic signed [ZWidth-1:0]     nx, ny;
  logic [CntWidth+StepsWidth-1:0] steps_ext;

  assign m_x = $signed({{(OffWidth-IndexWidth-1){1'b0}}, col_r, 1'b1})
             - $signed(OffWidth'(ImageSize));
  assign m_y = $signed({{(OffWidth-IndexWidth-1){1'b0}}, row_r, 1'b1})
             - $signed(OffWidth'(ImageSize));

  assign sum_x = SumWidth'(centre_x) + SumWidth'(off_x_r);
  assign sum_y = SumWidth'(centre_y) + SumWidth'(off_y_r);

  assign abs_x = z_x_r[ZWidth-1] ? -z_x_r : z_x_r;
  assign abs_y = z_y_r[ZWidth-1] ? -z_y_r : z_y_r;
  assign mag_x = abs_x[MagWidth-1:0];
  assign mag_y = abs_y[MagWidth-1:0];
  assign xh    = mag_x[MagWidth-1:LoWidth];
  assign xl    = mag_x[LoWidth-1:0];
  assign yh    = mag_y[MagWidth-1:LoWidth];
  assign yl    = mag_y[LoWidth-1:0];

  assign xx_nxt = (ProdWidth'(xhh_r) << (2*LoWidth)) + (ProdWidth'(xhl_r) << (LoWidth+1))
                + ProdWidth'(xll_r);
  assign yy_nxt = (ProdWidth'(yhh_r) << (2*LoWidth)) + (ProdWidth'(yhl_r) << (LoWidth+1))
                + ProdWidth'(yll_r);
  assign xy_nxt = (ProdWidth'(xyhh_r) << (2*LoWidth))
                + ((ProdWidth'(xyhl_r) + ProdWidth'(xylh_r)) << LoWidth)
                + ProdWidth'(xyll_r);

  assign r2     = {1'b0, xx_r} + {1'b0, yy_r};
  assign escape = |r2[ProdWidth:EscBit];

  // next iterate; the truncation is exact whenever the point has not escaped
  assign diff    = $signed({1'b0, xx_r}) - $signed({1'b0, yy_r});
  assign diff_sh = diff >>> FracBits;
  assign p2      = $signed({1'b0, xy_r, 1'b0});
  assign p2_sgn  = xy_neg_r ? -p2 : p2;
  assign p2_sh   = p2_sgn >>> FracBits;
  assign nx      = $signed(diff_sh[ZWidth-1:0]) + ZWidth'(c_x_r);
  assign ny      = $signed(p2_sh[ZWidth-1:0]) + ZWidth'(c_y_r);

  assign sts.finished = escape || (steps_r == CntWidth'(MAX_STEPS));

  assign steps_ext    = {{StepsWidth{1'b0}}, steps_r};
  assign escape_steps = steps_ext[StepsWidth-1:0];

  always_ff @(posedge clk) begin
    if (cmd.pix_load) begin
      col_r <= pixel_column;
      row_r <= pixel_row;
    end
    if (cmd.offset_calc) begin
      off_x_r <= (m_x <<< (FracBits - 1)) >>> zoom_level;
      off_y_r <= (m_y <<< (FracBits - 1)) >>> zoom_level;
    end
    if (cmd.point_load) begin
      c_x_r   <= sat_coord(sum_x);
      c_y_r   <= sat_coord(sum_y);
      // first step from z = 0 lands on c
      z_x_r   <= ZWidth'(sat_coord(sum_x));
      z_y_r   <= ZWidth'(sat_coord(sum_y));
      steps_r <= CntWidth'(1);
    end
    if (cmd.mul_en) begin
      xhh_r        <= (2*HiWidth)'(xh) * (2*HiWidth)'(xh);
      xhl_r        <= (HiWidth+LoWidth)'(xh) * (HiWidth+LoWidth)'(xl);
      xll_r        <= (2*LoWidth)'(xl) * (2*LoWidth)'(xl);
      yhh_r        <= (2*HiWidth)'(yh) * (2*HiWidth)'(yh);
      yhl_r        <= (HiWidth+LoWidth)'(yh) * (HiWidth+LoWidth)'(yl);
      yll_r        <= (2*LoWidth)'(yl) * (2*LoWidth)'(yl);
      xyhh_r       <= (2*HiWidth)'(xh) * (2*HiWidth)'(yh);
      xyhl_r       <= (HiWidth+LoWidth)'(xh) * (HiWidth+LoWidth)'(yl);
      xylh_r       <= (HiWidth+LoWidth)'(yh) * (HiWidth+LoWidth)'(xl);
      xyll_r       <= (2*LoWidth)'(xl) * (2*LoWidth)'(yl);
      xy_neg_mul_r <= z_x_r[ZWidth-1] ^ z_y_r[ZWidth-1];
    end
    if (cmd.sum_en) begin
      xx_r     <= xx_nxt;
      yy_r     <= yy_nxt;
      xy_r     <= xy_nxt;
      xy_neg_r <= xy_neg_mul_r;
    end
    if (cmd.z_step) begin
      z_x_r   <= nx;
      z_y_r   <= ny;
      steps_r <= steps_r + CntWidth'(1);
    end
  end

  a_cmd_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command in a cycle");

  a_step_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.z_step |-> (steps_r < CntWidth'(MAX_STEPS)) && !escape)
    else $error("iterate advanced at step limit or after escape");

endmodule

// File: rtl/mandelbrot_escape_time_core.sv
// Mandelbrot escape-time core. Each input word carries one pixel's column and
// row (row 0 at the bottom) of a 512 x 512 tile whose centre and zoom are set
// through the cfg write port (index 0 centre real, 1 centre imaginary, both
// signed 4.44; index 2 zoom, pixel size 2^-zoom); write them only while idle.
// The core forms the pixel-centre point c, iterates z = z*z + c from zero and
// returns the step count until |z|^2 >= 4 or MAX_STEPS steps. One pixel is in
// flight at a time: the next pixel is accepted only once the last result has
// been loaded into the output register. Each step runs through one shared set
// of ten 24x24 multipliers (partial products, product sums, escape test and
// update). A finished result waits in the output register without blocking
// the next pixel; the count is reported modulo 512.
module mandelbrot_escape_time_core #(
  parameter int MAX_STEPS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [8:0] pixel_column, [17:9] pixel_row
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [8:0] escape_steps
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_wdata
);
  import mbe_pkg::*;

  logic signed [CfgWidth-1:0]   centre_x_r, centre_y_r;
  logic        [ZoomWidth-1:0]  zoom_r;
  logic                         out_valid_r;
  logic        [StepsWidth-1:0] out_data_r;
  logic        [StepsWidth-1:0] escape_steps;
  logic                         out_free;
  logic                         out_load;
  mbe_cmd_t                     cmd;
  mbe_sts_t                     sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_x_r <= '0;
      centre_y_r <= '0;
      zoom_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTRE_X: centre_x_r <= cfg_wdata[CfgWidth-1:0];
        REG_CENTRE_Y: centre_y_r <= cfg_wdata[CfgWidth-1:0];
        REG_ZOOM:     zoom_r     <= cfg_wdata[ZoomWidth-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= escape_steps;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(16-StepsWidth){1'b0}}, out_data_r};

  mbe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .out_free (out_free),
    .out_load (out_load),
    .cmd      (cmd),
    .sts      (sts)
  );

  mbe_datapath #(
    .MAX_STEPS (MAX_STEPS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .pixel_column (in_tdata[8:0]),
    .pixel_row    (in_tdata[17:9]),
    .centre_x     (centre_x_r),
    .centre_y     (centre_y_r),
    .zoom_level   (zoom_r),
    .escape_steps (escape_steps)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second pixel accepted while one is in flight");

  a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !out_valid_r || out_tready)
    else $error("result overwrote a word not yet taken");

endmodule
